### rtl/lsfd_pkg.sv
// ----------------------------------------------------------------------------
// lsfd_pkg: shared types, codes and microcode for the LED strip frame driver
// Holds the command codes, byte selects, jump conditions, the control word
// layout and the microcode ROM used by the sequencer.
// ----------------------------------------------------------------------------
package lsfd_pkg;

   // default strip length
   localparam int NUM_PIXELS_DEF = 8;

   // field widths
   localparam int MODE_W   = 3;
   localparam int PIXNUM_W = 4;
   localparam int CHAN_W   = 8;
   localparam int COLOR_W  = 3 * CHAN_W;
   localparam int BRIGHT_W = 5;
   localparam int STEP_W   = 3;

   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 5'd31;
   localparam logic [CHAN_W-1:0]   HDR_BASE     = 8'hE0;
   localparam logic [CHAN_W-1:0]   BYTE_ZERO    = 8'h00;
   localparam logic [CHAN_W-1:0]   BYTE_ONES    = 8'hFF;

   // command codes
   localparam logic [MODE_W-1:0] MODE_SET_ALL = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SET_ONE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_OFF_ONE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ON_ONE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BLANK   = 3'd4;

   // output byte selects
   localparam logic [2:0] SEL_ZERO  = 3'd0;
   localparam logic [2:0] SEL_HDR   = 3'd1;
   localparam logic [2:0] SEL_BLUE  = 3'd2;
   localparam logic [2:0] SEL_GREEN = 3'd3;
   localparam logic [2:0] SEL_RED   = 3'd4;
   localparam logic [2:0] SEL_ONES  = 3'd5;

   // jump conditions
   localparam logic [1:0] JC_NONE = 2'd0;  // fall through
   localparam logic [1:0] JC_BAD  = 2'd1;  // unknown command: back to target
   localparam logic [1:0] JC_QUAD = 2'd2;  // more bytes left in a 4-byte group
   localparam logic [1:0] JC_PIX  = 2'd3;  // more pixels left

   // program steps
   localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_UPDATE = 3'd1;
   localparam logic [STEP_W-1:0] STEP_START  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_HDR    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_BLUE   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_GREEN  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_RED    = 3'd6;
   localparam logic [STEP_W-1:0] STEP_END    = 3'd7;

   // one microcode word
   typedef struct packed {
      logic              accept;
      logic              update;
      logic              emit;
      logic [2:0]        byte_sel;
      logic              quad;
      logic              pix_inc;
      logic [1:0]        cond;
      logic [STEP_W-1:0] target;
   } uword_type;

   // sequencer to datapath controls
   typedef struct packed {
      logic       accept;
      logic       update;
      logic       emit;
      logic [2:0] byte_sel;
      logic       last;
   } dp_ctl_type;

   // microcode ROM; the step after the end frame wraps to idle
   function automatic uword_type ucode(input logic [STEP_W-1:0] pc);
      uword_type w;
      w = '0;
      case (pc)
         STEP_IDLE: begin
            w.accept = 1'b1; w.cond = JC_BAD; w.target = STEP_IDLE;
         end
         STEP_UPDATE: begin
            w.update = 1'b1;
         end
         STEP_START: begin
            w.emit = 1'b1; w.byte_sel = SEL_ZERO; w.quad = 1'b1;
            w.cond = JC_QUAD; w.target = STEP_START;
         end
         STEP_HDR: begin
            w.emit = 1'b1; w.byte_sel = SEL_HDR;
         end
         STEP_BLUE: begin
            w.emit = 1'b1; w.byte_sel = SEL_BLUE;
         end
         STEP_GREEN: begin
            w.emit = 1'b1; w.byte_sel = SEL_GREEN;
         end
         STEP_RED: begin
            w.emit = 1'b1; w.byte_sel = SEL_RED; w.pix_inc = 1'b1;
            w.cond = JC_PIX; w.target = STEP_HDR;
         end
         STEP_END: begin
            w.emit = 1'b1; w.byte_sel = SEL_ONES; w.quad = 1'b1;
            w.cond = JC_QUAD; w.target = STEP_END;
         end
         default: begin
            w = '0;
         end
      endcase
      return w;
   endfunction

endpackage

### rtl/lsfd_req_if.sv
// ----------------------------------------------------------------------------
// lsfd_req_if: command channel
// Valid/ready channel carrying one strip command item.
// ----------------------------------------------------------------------------
interface lsfd_req_if;
   logic                          valid;
   logic                          ready;
   logic [lsfd_pkg::MODE_W-1:0]   mode;
   logic [lsfd_pkg::PIXNUM_W-1:0] pixel_number;
   logic [lsfd_pkg::CHAN_W-1:0]   red;
   logic [lsfd_pkg::CHAN_W-1:0]   green;
   logic [lsfd_pkg::CHAN_W-1:0]   blue;

   modport source (output valid, mode, pixel_number, red, green, blue, input ready);
   modport sink   (input valid, mode, pixel_number, red, green, blue, output ready);
endinterface

### rtl/lsfd_rsp_if.sv
// ----------------------------------------------------------------------------
// lsfd_rsp_if: frame byte channel
// Valid/ready channel carrying one strip frame byte per item.
// ----------------------------------------------------------------------------
interface lsfd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lsfd_pkg::CHAN_W-1:0] out_byte;
   logic                        last;
   logic                        index_error;

   modport source (output valid, out_byte, last, index_error, input ready);
   modport sink   (input valid, out_byte, last, index_error, output ready);
endinterface

### rtl/lsfd_seq.sv
// ----------------------------------------------------------------------------
// lsfd_seq: microcoded sequencer
// Step counter, microcode ROM, group and pixel counters, jump logic.
// ----------------------------------------------------------------------------
module lsfd_seq #(
   parameter int NUM_PIXELS = lsfd_pkg::NUM_PIXELS_DEF,
   localparam int PIX_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [lsfd_pkg::MODE_W-1:0] req_mode,
   input  logic                        loaded,
   output logic                        req_ready,
   output lsfd_pkg::dp_ctl_type        ctl,
   output logic [PIX_W-1:0]            pix
);

   localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(NUM_PIXELS - 1);

   logic [lsfd_pkg::STEP_W-1:0] pc_ff, pc_in;
   logic [1:0]                  quad_ff, quad_in;
   logic [PIX_W-1:0]            pix_ff, pix_in;
   lsfd_pkg::uword_type         uw;
   logic                        bad_mode;
   logic                        done;
   logic                        jump;

   // fetch
   assign uw       = lsfd_pkg::ucode(pc_ff);
   assign bad_mode = req_mode > lsfd_pkg::MODE_BLANK;

   // a step completes on a taken item, a loaded byte, or at once
   always_comb begin
      if (uw.accept) begin
         done = req_valid;
      end else if (uw.emit) begin
         done = loaded;
      end else begin
         done = 1'b1;
      end
   end

   // jump condition
   always_comb begin
      case (uw.cond)
         lsfd_pkg::JC_NONE: jump = 1'b0;
         lsfd_pkg::JC_BAD:  jump = bad_mode;
         lsfd_pkg::JC_QUAD: jump = quad_ff != 2'd3;
         lsfd_pkg::JC_PIX:  jump = pix_ff != PIX_LAST;
         default:           jump = 1'b0;
      endcase
   end

   // next step and counters
   always_comb begin
      pc_in   = pc_ff;
      quad_in = quad_ff;
      pix_in  = pix_ff;
      if (done) begin
         pc_in = jump ? uw.target : pc_ff + lsfd_pkg::STEP_W'(1);
         if (uw.quad) begin
            quad_in = quad_ff + 2'd1;
         end
         if (uw.pix_inc) begin
            pix_in = (pix_ff == PIX_LAST) ? '0 : pix_ff + PIX_W'(1);
         end
      end
      if (uw.update) begin
         pix_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= lsfd_pkg::STEP_IDLE;
         quad_ff <= '0;
         pix_ff  <= '0;
      end else begin
         pc_ff   <= pc_in;
         quad_ff <= quad_in;
         pix_ff  <= pix_in;
      end
   end

   // datapath controls
   assign req_ready    = uw.accept;
   assign ctl.accept   = uw.accept;
   assign ctl.update   = uw.update;
   assign ctl.emit     = uw.emit;
   assign ctl.byte_sel = uw.byte_sel;
   assign ctl.last     = uw.quad && (uw.byte_sel == lsfd_pkg::SEL_ONES) && (quad_ff == 2'd3);
   assign pix          = pix_ff;

   // a good command goes straight to the store update
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !bad_mode) |=> pc_ff == lsfd_pkg::STEP_UPDATE)
      else $error("good command did not reach update step");

   // pixel counter stays within the strip
   a_pix_range: assert property (@(posedge clock) disable iff (reset)
      pix_ff <= PIX_LAST)
      else $error("pixel counter out of range");

   // byte groups are always complete when idle
   a_quad_idle: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == lsfd_pkg::STEP_IDLE) |-> (quad_ff == 2'd0))
      else $error("partial byte group at idle");

endmodule

### rtl/lsfd_dp.sv
// ----------------------------------------------------------------------------
// lsfd_dp: datapath
// Command latch, colour and saved stores, brightness register, byte
// select and output register.
// ----------------------------------------------------------------------------
module lsfd_dp #(
   parameter int NUM_PIXELS = lsfd_pkg::NUM_PIXELS_DEF,
   localparam int PIX_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lsfd_pkg::dp_ctl_type          ctl,
   input  logic [PIX_W-1:0]              pix,
   input  logic                          csr_wr_en,
   input  logic [lsfd_pkg::BRIGHT_W-1:0] csr_wr_data,
   output logic                          loaded,
   lsfd_req_if.sink                      req_ch,
   lsfd_rsp_if.source                    rsp_ch
);

   localparam int CW = lsfd_pkg::CHAN_W;

   logic [lsfd_pkg::MODE_W-1:0]   mode_ff;
   logic [PIX_W-1:0]              idx_ff;
   logic [lsfd_pkg::COLOR_W-1:0]  color_ff;
   logic                          err_ff;
   logic [lsfd_pkg::BRIGHT_W-1:0] bright_ff;
   logic [lsfd_pkg::COLOR_W-1:0]  pixel_ff [NUM_PIXELS];
   logic [lsfd_pkg::COLOR_W-1:0]  pixel_in [NUM_PIXELS];
   logic [lsfd_pkg::COLOR_W-1:0]  saved_ff [NUM_PIXELS];
   logic [lsfd_pkg::COLOR_W-1:0]  saved_in [NUM_PIXELS];
   logic [PIX_W-1:0]              rd_idx;
   logic [lsfd_pkg::COLOR_W-1:0]  pix_rd;
   logic [lsfd_pkg::COLOR_W-1:0]  saved_rd;
   logic [lsfd_pkg::COLOR_W-1:0]  frame_color;
   logic                          take;
   logic                          pix_cmd;
   logic                          num_ok;
   logic [lsfd_pkg::PIXNUM_W-1:0] num_m1;
   logic [CW-1:0]                 byte_sel;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                 out_byte_ff;
   logic                          last_ff;
   logic                          err_out_ff;

   // command latch
   assign take    = ctl.accept && req_ch.valid;
   assign pix_cmd = (req_ch.mode == lsfd_pkg::MODE_SET_ONE) ||
                    (req_ch.mode == lsfd_pkg::MODE_OFF_ONE) ||
                    (req_ch.mode == lsfd_pkg::MODE_ON_ONE);
   assign num_ok  = (req_ch.pixel_number != '0) &&
                    (req_ch.pixel_number <= lsfd_pkg::PIXNUM_W'(NUM_PIXELS));
   assign num_m1  = req_ch.pixel_number - lsfd_pkg::PIXNUM_W'(1);
   assign req_ch.ready = ctl.accept;

   always_ff @(posedge clock) begin
      if (take) begin
         mode_ff  <= req_ch.mode;
         idx_ff   <= num_m1[PIX_W-1:0];
         color_ff <= {req_ch.red, req_ch.green, req_ch.blue};
         err_ff   <= pix_cmd && !num_ok;
      end
   end

   // brightness register
   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= lsfd_pkg::BRIGHT_RESET;
      end else if (csr_wr_en) begin
         bright_ff <= csr_wr_data;
      end
   end

   // single read port per store: command pixel during update, else frame pixel
   assign rd_idx   = ctl.update ? idx_ff : pix;
   assign pix_rd   = pixel_ff[rd_idx];
   assign saved_rd = saved_ff[rd_idx];

   // store update
   always_comb begin
      pixel_in = pixel_ff;
      saved_in = saved_ff;
      if (ctl.update && !err_ff) begin
         case (mode_ff)
            lsfd_pkg::MODE_SET_ALL: begin
               for (int i = 0; i < NUM_PIXELS; i++) begin
                  pixel_in[i] = color_ff;
               end
            end
            lsfd_pkg::MODE_SET_ONE: begin
               pixel_in[idx_ff] = color_ff;
            end
            lsfd_pkg::MODE_OFF_ONE: begin
               saved_in[idx_ff] = pix_rd;
               pixel_in[idx_ff] = '0;
            end
            lsfd_pkg::MODE_ON_ONE: begin
               pixel_in[idx_ff] = saved_rd;
            end
            default: begin
               pixel_in = pixel_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PIXELS; i++) begin
            pixel_ff[i] <= '0;
            saved_ff[i] <= '0;
         end
      end else begin
         pixel_ff <= pixel_in;
         saved_ff <= saved_in;
      end
   end

   // frame byte select; blank sends black
   assign frame_color = (mode_ff == lsfd_pkg::MODE_BLANK) ? '0 : pix_rd;

   always_comb begin
      case (ctl.byte_sel)
         lsfd_pkg::SEL_ZERO:  byte_sel = lsfd_pkg::BYTE_ZERO;
         lsfd_pkg::SEL_HDR:   byte_sel = lsfd_pkg::HDR_BASE |
                                         CW'(bright_ff);
         lsfd_pkg::SEL_BLUE:  byte_sel = frame_color[CW-1:0];
         lsfd_pkg::SEL_GREEN: byte_sel = frame_color[2*CW-1:CW];
         lsfd_pkg::SEL_RED:   byte_sel = frame_color[3*CW-1:2*CW];
         lsfd_pkg::SEL_ONES:  byte_sel = lsfd_pkg::BYTE_ONES;
         default:             byte_sel = lsfd_pkg::BYTE_ZERO;
      endcase
   end

   // output register
   assign loaded       = ctl.emit && (!rsp_valid_ff || rsp_ch.ready);
   assign rsp_valid_in = loaded ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (loaded) begin
         out_byte_ff <= byte_sel;
         last_ff     <= ctl.last;
         err_out_ff  <= err_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_byte    = out_byte_ff;
   assign rsp_ch.last        = last_ff;
   assign rsp_ch.index_error = err_out_ff;

   // the closing byte of a frame is an end-frame byte
   a_last_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.last) |-> (rsp_ch.out_byte == lsfd_pkg::BYTE_ONES))
      else $error("last flag on a non end-frame byte");

endmodule

### rtl/led_strip_frame_driver.sv
// Ordering: an accepted command is followed by the store update step, then by
// the frame bytes through the output register. Throughput: one frame byte per
// cycle while the output is not back-pressured; a command runs the idle step,
// store update, then the frame bytes. The microcode step counter paces
// everything, one step per cycle unless a step waits for a command item or for
// output space. Unknown commands are taken and produce no bytes. Reset
// (synchronous): both colour stores black, brightness 31, sequencer idle.
// led_strip_frame_driver: serial RGB LED strip frame driver
// Updates the pixel colour store per command and streams the full strip
// frame as bytes for every known command.
// ----------------------------------------------------------------------------
module led_strip_frame_driver #(
   parameter int NUM_PIXELS = lsfd_pkg::NUM_PIXELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   lsfd_req_if.sink                      req_ch,
   lsfd_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [lsfd_pkg::BRIGHT_W-1:0] csr_wr_data
);

   localparam int PIX_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

   lsfd_pkg::dp_ctl_type ctl;
   logic [PIX_W-1:0]     pix;
   logic                 loaded;
   logic                 seq_ready;

   // program sequencer
   lsfd_seq #(
      .NUM_PIXELS (NUM_PIXELS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .loaded    (loaded),
      .req_ready (seq_ready),
      .ctl       (ctl),
      .pix       (pix)
   );

   // stores and output stage
   lsfd_dp #(
      .NUM_PIXELS (NUM_PIXELS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .pix         (pix),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .loaded      (loaded),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // the sequencer and datapath agree on when an item is taken
   a_ready_match: assert property (@(posedge clock) disable iff (reset)
      seq_ready == req_ch.ready)
      else $error("ready mismatch between sequencer and datapath");

endmodule
